[design/lcc_pkg.sv]
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants of the lift coefficient curve core
// Widths, fixed-point constants, register indexes, datapath ops, FSM states.
// ----------------------------------------------------------------------------
package lcc_pkg;

   localparam int VAL_W   = 24;
   localparam int SLOPE_W = 23;
   localparam int TOL_W   = 16;
   localparam int IDX_W   = 3;

   // iterative divider geometry
   localparam int DIV_NUM_W = 59;
   localparam int DIV_DEN_W = 43;
   localparam int DIV_QUO_W = 41;
   localparam int DIV_CNT_W = 6;

   // Q16 constants
   localparam logic [16:0] Q_ONE  = 17'd65536;
   localparam logic [16:0] K_KNEE = 17'd114815;
   localparam logic [16:0] S_C1   = 17'd102944;
   localparam logic [16:0] S_C3   = 17'd42334;
   localparam logic [16:0] S_C5   = 17'd5223;
   localparam logic [8:0]  S_C7   = 9'd307;
   localparam logic signed [45:0] LIM40 = 46'sd1099511627776;

   localparam logic signed [VAL_W-1:0] V_MAX = 24'sd8388607;
   localparam logic signed [VAL_W-1:0] V_MIN = -24'sd8388608;

   // register reset values
   localparam logic signed [VAL_W-1:0] LIFT_MAX_RST      = 24'sd78643;
   localparam logic signed [VAL_W-1:0] LIFT_ZERO_RST     = 24'sd13107;
   localparam logic [SLOPE_W-1:0]      LIFT_SLOPE_RST    = 23'd327680;
   localparam logic signed [VAL_W-1:0] ANGLE_MAX_RST     = 24'sd13107;
   localparam logic signed [VAL_W-1:0] ANGLE_ZL_RST      = -24'sd2621;
   localparam logic [TOL_W-1:0]        TOLERANCE_RST     = 16'd20;

   typedef enum logic [IDX_W-1:0] {
      REG_LIFT_MAX        = 3'd0,
      REG_LIFT_AT_ZERO    = 3'd1,
      REG_LIFT_SLOPE      = 3'd2,
      REG_ANGLE_MAX       = 3'd3,
      REG_ANGLE_ZERO_LIFT = 3'd4,
      REG_TOLERANCE       = 3'd5
   } reg_idx_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_KNEE_GO, OP_KNEE_CAP, OP_E, OP_D, OP_W, OP_AOA,
      OP_PH_GO, OP_X, OP_X2, OP_P1, OP_P2, OP_P3, OP_P4, OP_DMUL, OP_INNER,
      OP_SMUL, OP_LIFT, OP_UPDATE, OP_RESULT
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_KNEE_GO, ST_KNEE_WAIT, ST_E, ST_D, ST_W, ST_AOA, ST_CHECK,
      ST_PH_GO, ST_PH_WAIT, ST_X2, ST_P1, ST_P2, ST_P3, ST_P4, ST_DMUL,
      ST_INNER, ST_SMUL, ST_LIFT, ST_UPDATE, ST_RESULT
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic inverse;
      logic rounded;
      logic w_zero;
      logic found;
      logic step_limit;
      logic out_free;
   } dp_stat_type;

endpackage

[design/lcc_req_if.sv]
// ----------------------------------------------------------------------------
// lcc_req_if: request channel
// Carries the action bit and the operand of one item.
// ----------------------------------------------------------------------------
interface lcc_req_if import lcc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    action;
   logic signed [VAL_W-1:0] operand;

   modport source (output valid, action, operand, input ready);
   modport sink   (input valid, action, operand, output ready);
endinterface

[design/lcc_rsp_if.sv]
// ----------------------------------------------------------------------------
// lcc_rsp_if: response channel
// Carries the value and status of one result item.
// ----------------------------------------------------------------------------
interface lcc_rsp_if import lcc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic                    status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

[design/lcc_csr_if.sv]
// ----------------------------------------------------------------------------
// lcc_csr_if: register write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
interface lcc_csr_if import lcc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [VAL_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/lift_coefficient_curve_core.sv]
// ----------------------------------------------------------------------------
// lift_coefficient_curve_core: lift curve evaluation and inversion
// Takes an item on req_chan (action 0: lift at angle, 1: angle for lift) and
// returns one result item on rsp_chan; csr_chan writes the six curve registers.
//
// Usage:
//   Registers are written through csr_chan, which is always ready; write them
//   only while no item is in flight.
//   Forward items follow the linear part of the curve, the rounded region with
//   a zero rounding width, or the full rounded region; the knee and phase
//   divisions each wait on a shared 59-step bit-serial divider.
//   Inverse items run up to MAX_STEPS + 1 bisection steps.
//   One item is worked on at a time; req_chan.ready is high only while idle.
//   The result sits in an output register, so a new item is taken while the
//   previous result waits; if the receiver still stalls when the next result
//   is done, the core holds it until rsp_chan drains.
//   Reset is synchronous: it drops any item in flight, empties the output
//   register and restores the register defaults.
// ----------------------------------------------------------------------------
module lift_coefficient_curve_core import lcc_pkg::*; #(
   parameter int MAX_STEPS = 33
) (
   input  logic     clock,
   input  logic     reset,
   lcc_req_if.sink  req_chan,
   lcc_rsp_if.source rsp_chan,
   lcc_csr_if.sink  csr_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_chan.ready = 1'b1;

   lcc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   lcc_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_action  (req_chan.action),
      .in_operand (req_chan.operand),
      .csr_we     (csr_chan.valid),
      .csr_idx    (csr_chan.index),
      .csr_data   (csr_chan.data),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_value  (rsp_chan.value),
      .out_status (rsp_chan.status)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("core took a second item while busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status |-> rsp_chan.value == '0)
      else $error("failed inverse gave a nonzero value");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.op == OP_RESULT))
      else $error("response appeared without a result load");
`endif

endmodule

[design/lcc_div.sv]
// ----------------------------------------------------------------------------
// lcc_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; keeps the low quotient bits.
// ----------------------------------------------------------------------------
module lcc_div import lcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_QUO_W-1:0] quo
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], 1'b0};
         rem_in = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[design/lcc_dp.sv]
// ----------------------------------------------------------------------------
// lcc_dp: datapath of the lift coefficient curve core
// Registers, knee and phase division, sine polynomial, bisection, output reg.
// ----------------------------------------------------------------------------
module lcc_dp import lcc_pkg::*; #(
   parameter int MAX_STEPS = 33
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat,
   input  logic                    in_action,
   input  logic signed [VAL_W-1:0] in_operand,
   input  logic                    csr_we,
   input  logic [IDX_W-1:0]        csr_idx,
   input  logic [VAL_W-1:0]        csr_data,
   input  logic                    out_ready,
   output logic                    out_valid,
   output logic signed [VAL_W-1:0] out_value,
   output logic                    out_status
);

   localparam int SW = $clog2(MAX_STEPS + 1);

   // configuration
   logic signed [VAL_W-1:0] lift_max_ff, lift_zero_ff, angle_max_ff, angle_zl_ff;
   logic [SLOPE_W-1:0]      slope_ff;
   logic [TOL_W-1:0]        tol_ff;

   // item state
   logic                    action_ff;
   logic signed [VAL_W-1:0] operand_ff, left_ff, right_ff, aoa_ff, lift_ff;
   logic [SW-1:0]           step_ff;
   logic signed [41:0]      knee_ff, inner_ff;
   logic [41:0]             e_ff, d_ff;
   logic [42:0]             w_ff;
   logic [16:0]             x_ff, x2_ff, p_ff;
   logic                    sneg_ff;
   logic [43:0]             dm_ff;
   logic signed [65:0]      prod_ff;
   logic signed [VAL_W-1:0] res_val_ff, out_val_ff;
   logic                    res_st_ff, out_st_ff, out_valid_ff;

   logic                    div_done;
   logic [DIV_QUO_W-1:0]    div_quo;
   logic [DIV_NUM_W-1:0]    div_num;
   logic [DIV_DEN_W-1:0]    div_den;
   logic                    div_start;

   logic [SLOPE_W-1:0]      slope_eff;
   logic signed [24:0]      diff;
   logic [24:0]             diff_mag;
   logic signed [41:0]      am42, knee_new;
   logic [58:0]             d_prod;
   logic signed [44:0]      aoa45, am45, w45, lo_bound, ph_off;
   logic                    rounded;
   logic signed [24:0]      center_sum;
   logic [17:0]             t_low;
   logic [16:0]             f_low;
   logic [33:0]             x_sq, pm;
   logic [25:0]             c7_prod;
   logic [17:0]             pm_hi, om;
   logic [59:0]             dm_prod;
   logic signed [45:0]      inner_w, inner_c;
   logic signed [65:0]      mop_x, slope_x;
   logic signed [50:0]      lift_sum, lift_cap;
   logic signed [VAL_W-1:0] lift_sat;
   logic signed [24:0]      err_s;
   logic [24:0]             err_abs;
   logic                    step_limit, found;

   assign slope_eff = (slope_ff == '0) ? SLOPE_W'(1) : slope_ff;
   assign diff      = $signed({lift_max_ff[VAL_W-1], lift_max_ff})
                    - $signed({lift_zero_ff[VAL_W-1], lift_zero_ff});
   assign diff_mag  = diff[24] ? 25'(-diff) : diff;
   assign am42      = 42'(angle_max_ff);
   assign knee_new  = diff[24] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
   assign d_prod    = 59'(e_ff) * 59'(K_KNEE);

   assign aoa45    = 45'(aoa_ff);
   assign am45     = 45'(angle_max_ff);
   assign w45      = $signed({2'b00, w_ff});
   assign lo_bound = am45 - w45;
   assign ph_off   = aoa45 - am45 + w45;
   assign rounded  = (knee_ff <= am42) && !(aoa45 < lo_bound);

   assign div_start = (cmd.op == OP_KNEE_GO) || (cmd.op == OP_PH_GO);
   assign div_num   = (cmd.op == OP_KNEE_GO) ? {18'd0, diff_mag, 16'd0}
                                             : {ph_off[42:0], 16'd0};
   assign div_den   = (cmd.op == OP_KNEE_GO) ? {20'd0, slope_eff} : w_ff;

   lcc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign center_sum = 25'(left_ff) + 25'(right_ff);
   assign t_low      = div_quo[17:0];
   // odd quarter turns run the sine backward
   assign f_low      = t_low[16] ? (Q_ONE - {1'b0, t_low[15:0]}) : {1'b0, t_low[15:0]};
   assign x_sq       = 34'(x_ff) * 34'(x_ff);
   assign c7_prod    = 26'(x2_ff) * 26'(S_C7);
   assign pm         = 34'((cmd.op == OP_P4) ? x_ff : x2_ff) * 34'(p_ff);
   assign pm_hi      = pm[33:16];
   assign om         = sneg_ff ? (18'(Q_ONE) + 18'(p_ff)) : (18'(Q_ONE) - 18'(p_ff));
   assign dm_prod    = 60'(d_ff) * 60'(om);

   always_comb begin
      inner_w = w_ff == '0 ? 46'(knee_ff) : 46'(knee_ff) - $signed({2'b00, dm_ff});
      if (inner_w > LIM40) begin
         inner_c = LIM40;
      end else if (inner_w < -LIM40) begin
         inner_c = -LIM40;
      end else begin
         inner_c = inner_w;
      end
   end

   assign mop_x   = rounded ? 66'(inner_ff) : 66'(aoa_ff);
   assign slope_x = $signed({43'd0, slope_eff});

   always_comb begin
      lift_sum = 51'($signed(prod_ff[65:16])) + 51'(lift_zero_ff);
      lift_cap = (!rounded && lift_sum > 51'(lift_max_ff)) ? 51'(lift_max_ff) : lift_sum;
      if (lift_cap > 51'(V_MAX)) begin
         lift_sat = V_MAX;
      end else if (lift_cap < 51'(V_MIN)) begin
         lift_sat = V_MIN;
      end else begin
         lift_sat = lift_cap[VAL_W-1:0];
      end
   end

   assign err_s      = 25'(lift_ff) - 25'(operand_ff);
   assign err_abs    = err_s[24] ? 25'(-err_s) : err_s;
   assign found      = err_abs <= 25'(tol_ff);
   assign step_limit = step_ff >= SW'(MAX_STEPS);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lift_max_ff  <= LIFT_MAX_RST;
         lift_zero_ff <= LIFT_ZERO_RST;
         slope_ff     <= LIFT_SLOPE_RST;
         angle_max_ff <= ANGLE_MAX_RST;
         angle_zl_ff  <= ANGLE_ZL_RST;
         tol_ff       <= TOLERANCE_RST;
      end else if (csr_we) begin
         case (csr_idx)
            REG_LIFT_MAX:        lift_max_ff  <= csr_data;
            REG_LIFT_AT_ZERO:    lift_zero_ff <= csr_data;
            REG_LIFT_SLOPE:      slope_ff     <= csr_data[SLOPE_W-1:0];
            REG_ANGLE_MAX:       angle_max_ff <= csr_data;
            REG_ANGLE_ZERO_LIFT: angle_zl_ff  <= csr_data;
            REG_TOLERANCE:       tol_ff       <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath operations
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            action_ff  <= in_action;
            operand_ff <= in_operand;
            left_ff    <= angle_zl_ff;
            right_ff   <= angle_max_ff;
            step_ff    <= '0;
         end
         OP_KNEE_CAP: knee_ff <= knee_new;
         OP_E:        e_ff    <= 42'(am42 - knee_ff);
         OP_D:        d_ff    <= d_prod[57:16];
         OP_W:        w_ff    <= {1'b0, d_ff} + {1'b0, e_ff};
         OP_AOA:      aoa_ff  <= action_ff ? center_sum[24:1] : operand_ff;
         OP_X: begin
            x_ff    <= f_low;
            sneg_ff <= t_low[17];
         end
         OP_X2:    x2_ff <= x_sq[32:16];
         OP_P1:    p_ff  <= S_C5 - 17'(c7_prod[25:16]);
         OP_P2:    p_ff  <= S_C3 - pm_hi[16:0];
         OP_P3:    p_ff  <= S_C1 - pm_hi[16:0];
         OP_P4:    p_ff  <= (pm_hi > 18'(Q_ONE)) ? Q_ONE : pm_hi[16:0];
         OP_DMUL:  dm_ff <= dm_prod[59:16];
         OP_INNER: inner_ff <= 42'(inner_c);
         OP_SMUL:  prod_ff  <= mop_x * slope_x;
         OP_LIFT: begin
            lift_ff    <= lift_sat;
            res_val_ff <= lift_sat;
            res_st_ff  <= 1'b0;
         end
         OP_UPDATE: begin
            if (lift_ff > operand_ff) begin
               right_ff <= aoa_ff;
            end else begin
               left_ff <= aoa_ff;
            end
            step_ff <= step_ff + 1'b1;
            if (step_limit) begin
               res_val_ff <= '0;
               res_st_ff  <= 1'b1;
            end else begin
               res_val_ff <= aoa_ff;
               res_st_ff  <= 1'b0;
            end
         end
         OP_RESULT: begin
            out_val_ff <= res_val_ff;
            out_st_ff  <= res_st_ff;
         end
         OP_NONE, OP_KNEE_GO, OP_PH_GO: ;
         default: ;
      endcase
   end

   // output register, separate from the working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESULT) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign stat.div_done   = div_done;
   assign stat.inverse    = action_ff;
   assign stat.rounded    = rounded;
   assign stat.w_zero     = (w_ff == '0);
   assign stat.found      = found;
   assign stat.step_limit = step_limit;
   assign stat.out_free   = !out_valid_ff || out_ready;

   assign out_valid  = out_valid_ff;
   assign out_value  = out_val_ff;
   assign out_status = out_st_ff;

endmodule

[design/lcc_ctrl.sv]
// ----------------------------------------------------------------------------
// lcc_ctrl: sequencer of the lift coefficient curve core
// Steps the datapath through knee, phase, sine, lift and bisection updates.
// ----------------------------------------------------------------------------
module lcc_ctrl import lcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (in_valid) state_in = ST_KNEE_GO;
         ST_KNEE_GO:   state_in = ST_KNEE_WAIT;
         ST_KNEE_WAIT: if (stat.div_done) state_in = ST_E;
         ST_E:         state_in = ST_D;
         ST_D:         state_in = ST_W;
         ST_W:         state_in = ST_AOA;
         ST_AOA:       state_in = ST_CHECK;
         ST_CHECK: begin
            priority if (stat.rounded && !stat.w_zero) state_in = ST_PH_GO;
            else if (stat.rounded)                     state_in = ST_INNER;
            else                                       state_in = ST_SMUL;
         end
         ST_PH_GO:   state_in = ST_PH_WAIT;
         ST_PH_WAIT: if (stat.div_done) state_in = ST_X2;
         ST_X2:      state_in = ST_P1;
         ST_P1:      state_in = ST_P2;
         ST_P2:      state_in = ST_P3;
         ST_P3:      state_in = ST_P4;
         ST_P4:      state_in = ST_DMUL;
         ST_DMUL:    state_in = ST_INNER;
         ST_INNER:   state_in = ST_SMUL;
         ST_SMUL:    state_in = ST_LIFT;
         ST_LIFT:    state_in = stat.inverse ? ST_UPDATE : ST_RESULT;
         ST_UPDATE: begin
            priority if (stat.step_limit || stat.found) state_in = ST_RESULT;
            else                                        state_in = ST_AOA;
         end
         ST_RESULT:  if (stat.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready = 1'b0;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) cmd.op = OP_LOAD;
         end
         ST_KNEE_GO:   cmd.op = OP_KNEE_GO;
         ST_KNEE_WAIT: if (stat.div_done) cmd.op = OP_KNEE_CAP;
         ST_E:         cmd.op = OP_E;
         ST_D:         cmd.op = OP_D;
         ST_W:         cmd.op = OP_W;
         ST_AOA:       cmd.op = OP_AOA;
         ST_CHECK:     cmd.op = OP_NONE;
         ST_PH_GO:     cmd.op = OP_PH_GO;
         ST_PH_WAIT:   if (stat.div_done) cmd.op = OP_X;
         ST_X2:        cmd.op = OP_X2;
         ST_P1:        cmd.op = OP_P1;
         ST_P2:        cmd.op = OP_P2;
         ST_P3:        cmd.op = OP_P3;
         ST_P4:        cmd.op = OP_P4;
         ST_DMUL:      cmd.op = OP_DMUL;
         ST_INNER:     cmd.op = OP_INNER;
         ST_SMUL:      cmd.op = OP_SMUL;
         ST_LIFT:      cmd.op = OP_LIFT;
         ST_UPDATE:    cmd.op = OP_UPDATE;
         ST_RESULT:    if (stat.out_free) cmd.op = OP_RESULT;
         default:      cmd.op = OP_NONE;
      endcase
   end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lift coefficient curve core
// Drives lift and angle requests through the request channel, rewrites the
// curve registers between phases, and compares every response item against
// a fixed-point curve predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_top;
   import lcc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit ACT_LIFT  = 1'b0;
   localparam bit ACT_ANGLE = 1'b1;
   localparam int STEP_LIMIT = 33;
   localparam int STALL_LIMIT = 20000;
   localparam longint QONE = 65536;
   localparam longint LIM = 64'sd1 << 40;

   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    status;
   } curve_result_type;

   logic clock;
   logic reset;

   lcc_req_if req_chan ();
   lcc_rsp_if rsp_chan ();
   lcc_csr_if csr_chan ();

   lift_coefficient_curve_core #(.MAX_STEPS(STEP_LIMIT)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // curve registers as the bench sees them
   longint lift_max_r, lift_zero_r, slope_r, angle_max_r, angle_zl_r, tol_r;

   curve_result_type result_q[$];
   int  send_idle_pct;
   int  rsp_stall_pct;
   int  quiet_cycles;
   bit  failed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sext24(input logic [VAL_W-1:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint sat_value(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // quarter-turn sine polynomial, x in [0, 1.0] Q16
   function automatic longint quarter_sine(input longint x);
      longint x2, p;
      x2 = (x * x) >>> 16;
      p  = 5223 - ((x2 * 307) >>> 16);
      p  = 42334 - ((x2 * p) >>> 16);
      p  = 102944 - ((x2 * p) >>> 16);
      p  = (x * p) >>> 16;
      return (p > QONE) ? QONE : p;
   endfunction

   function automatic longint lift_at(input longint aoa);
      longint slope, knee, e, d, w, inner, s, f, x, lin;
      longint unsigned num, t, q;
      slope = (slope_r != 0) ? slope_r : 1;
      knee  = ((lift_max_r - lift_zero_r) * QONE) / slope;
      if (knee <= angle_max_r) begin
         e = angle_max_r - knee;
         d = (e * 114815) >>> 16;
         w = d + e;
         if (!(aoa < angle_max_r - w)) begin
            if (w == 0) begin
               inner = knee;
            end else begin
               num = longint'(aoa - angle_max_r + w);
               t   = (num << 16) / longint'(w);
               q   = (t >> 16) & 3;
               f   = longint'(t & 64'hFFFF);
               x   = q[0] ? QONE - f : f;
               s   = quarter_sine(x);
               if (q[1]) s = -s;
               inner = knee - ((d * (QONE - s)) >>> 16);
            end
            if (inner > LIM) inner = LIM;
            if (inner < -LIM) inner = -LIM;
            return sat_value(lift_zero_r + ((slope * inner) >>> 16));
         end
      end
      lin = lift_zero_r + ((aoa * slope) >>> 16);
      if (lin > lift_max_r) lin = lift_max_r;
      return sat_value(lin);
   endfunction

   function automatic curve_result_type predict_curve(input bit act,
                                                      input logic [VAL_W-1:0] opnd);
      curve_result_type r;
      longint target, lo, hi, mid, approx, err;
      r.value  = '0;
      r.status = 1'b0;
      target = sext24(opnd);
      if (act == ACT_LIFT) begin
         r.value = VAL_W'(lift_at(target));
      end else begin
         lo = angle_zl_r;
         hi = angle_max_r;
         for (int step = 0; ; step++) begin
            mid    = (lo + hi) >>> 1;
            approx = lift_at(mid);
            if (approx > target) hi = mid;
            else lo = mid;
            if (step >= STEP_LIMIT) begin
               r.status = 1'b1;
               break;
            end
            err = approx - target;
            if (err < 0) err = -err;
            if (err <= tol_r) begin
               r.value = VAL_W'(mid);
               break;
            end
         end
      end
      return r;
   endfunction

   task automatic send_item(input bit act, input logic [VAL_W-1:0] opnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.action  <= act;
      req_chan.operand <= opnd;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      result_q.push_back(predict_curve(act, opnd));
   endtask

   // hold the request side until every pending result has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [VAL_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         REG_LIFT_MAX:        lift_max_r  = sext24(data);
         REG_LIFT_AT_ZERO:    lift_zero_r = sext24(data);
         REG_LIFT_SLOPE:      slope_r     = longint'(data[SLOPE_W-1:0]);
         REG_ANGLE_MAX:       angle_max_r = sext24(data);
         REG_ANGLE_ZERO_LIFT: angle_zl_r  = sext24(data);
         REG_TOLERANCE:       tol_r       = longint'(data[TOL_W-1:0]);
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_curve(input longint lmax, input longint lz, input longint sl,
                             input longint amax, input longint azl, input longint tol);
      drain();
      write_reg(REG_LIFT_MAX, lmax[VAL_W-1:0]);
      write_reg(REG_LIFT_AT_ZERO, lz[VAL_W-1:0]);
      write_reg(REG_LIFT_SLOPE, sl[VAL_W-1:0]);
      write_reg(REG_ANGLE_MAX, amax[VAL_W-1:0]);
      write_reg(REG_ANGLE_ZERO_LIFT, azl[VAL_W-1:0]);
      write_reg(REG_TOLERANCE, tol[VAL_W-1:0]);
   endtask

   // angle near the top of the curve, where the rounded region lives
   function automatic logic [VAL_W-1:0] angle_near_knee();
      longint off;
      off = longint'($urandom_range((1 << $urandom_range(20, 4)) - 1));
      if ($urandom_range(1)) off = -off;
      return VAL_W'(sat_value(angle_max_r + off));
   endfunction

   task automatic test_reset_curve();
      send_item(ACT_LIFT, 24'h000000);
      send_item(ACT_LIFT, 24'h7FFFFF);
      send_item(ACT_LIFT, 24'h800000);
      send_item(ACT_LIFT, 24'hFFFFFF);
      send_item(ACT_LIFT, 24'd13107);
      send_item(ACT_LIFT, 24'd9000);
      send_item(ACT_LIFT, 24'd20000);
      send_item(ACT_ANGLE, 24'd40000);
      send_item(ACT_ANGLE, 24'h000000);
      send_item(ACT_ANGLE, 24'h7FFFFF);
      send_item(ACT_ANGLE, 24'h800000);
      drain();
   endtask

   task automatic test_corner_curves();
      // knee exactly at angle_max: rounding width is zero
      load_curve(65536 + 20000, 65536, 65536, 20000, -5000, 10);
      send_item(ACT_LIFT, 24'd20000);
      send_item(ACT_LIFT, 24'd30000);
      send_item(ACT_ANGLE, 24'd70000);
      // zero slope, extreme lift registers
      load_curve(8388607, -8388608, 0, 8388607, -8388608, 65535);
      send_item(ACT_LIFT, 24'h7FFFFF);
      send_item(ACT_LIFT, 24'h800000);
      send_item(ACT_ANGLE, 24'd0);
      // knee far below angle_max drives the rounded term into its clamp
      load_curve(-8388608, 8388607, 0, 8388607, 8388607, 0);
      send_item(ACT_LIFT, 24'h7FFFFF);
      send_item(ACT_LIFT, 24'h000000);
      send_item(ACT_ANGLE, 24'h123456);
      // steepest slope, inverted search bounds
      load_curve(0, 0, 8388607, -8388608, 8388607, 0);
      send_item(ACT_LIFT, 24'h800001);
      send_item(ACT_ANGLE, 24'h7FFFFF);
      drain();
   endtask

   task automatic test_random_phase(input int items, input int idle, input int stall);
      longint lo, hi, ang;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         case ($urandom_range(9))
            0: send_item(ACT_LIFT, VAL_W'($urandom()));
            1, 2, 3, 4, 5: send_item(ACT_LIFT, angle_near_knee());
            6: send_item(1'($urandom_range(1)), VAL_W'($urandom()));
            default: begin
               lo = angle_zl_r;
               hi = angle_max_r;
               if (lo > hi) ang = lo;
               else ang = lo + longint'($urandom_range(32'(hi - lo)));
               send_item(ACT_ANGLE, VAL_W'(sat_value(lift_at(ang) +
                         longint'($urandom_range(64)) - 32)));
            end
         endcase
         // sender waits for the pipe to empty now and then
         if ($urandom_range(49) == 0) drain();
      end
   endtask

   task automatic test_random_curves();
      load_curve(78643, 13107, 327680, 13107, -2621, 20);
      test_random_phase(100, 0, 0);
      load_curve(65536 + $urandom_range(65536), $urandom_range(20000),
                 131072 + $urandom_range(400000), 10000 + $urandom_range(20000),
                 -longint'($urandom_range(5000)), $urandom_range(200));
      test_random_phase(100, 65, 0);
      load_curve(65536 + $urandom_range(131072), -longint'($urandom_range(20000)),
                 65536 + $urandom_range(600000), 5000 + $urandom_range(40000),
                 -longint'($urandom_range(20000)), $urandom_range(5000));
      test_random_phase(100, 0, 65);
      load_curve(sext24(VAL_W'($urandom())), sext24(VAL_W'($urandom())), $urandom(),
                 sext24(VAL_W'($urandom())), sext24(VAL_W'($urandom())), $urandom());
      test_random_phase(50, 8, 8);
      load_curve(100000, 5000, 300000, 16000, -3000, $urandom_range(65535));
      test_random_phase(50, 8, 8);
      drain();
   endtask

   // response side: random stall, compare in arrival order
   always @(posedge clock) begin
      curve_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (result_q.size() == 0) begin
               $display("%0t: unexpected result value=%0d status=%0d", $time,
                        rsp_chan.value, rsp_chan.status);
               failed = 1'b1;
            end else begin
               want = result_q.pop_front();
               if (rsp_chan.value !== want.value)
                  begin
                  $display("%0t: value mismatch expected=%0d actual=%0d", $time,
                           want.value, rsp_chan.value);
                  failed = 1'b1;
               end
               if (rsp_chan.status !== want.status) begin
                  $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                           want.status, rsp_chan.status);
                  failed = 1'b1;
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // cycles with no item moving on any channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      failed         = 1'b0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      lift_max_r     = LIFT_MAX_RST;
      lift_zero_r    = LIFT_ZERO_RST;
      slope_r        = LIFT_SLOPE_RST;
      angle_max_r    = ANGLE_MAX_RST;
      angle_zl_r     = ANGLE_ZL_RST;
      tol_r          = TOLERANCE_RST;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.action  = ACT_LIFT;
      req_chan.operand = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = REG_LIFT_MAX;
      csr_chan.data    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_curve();
      test_corner_curves();
      test_random_curves();

      repeat (200) @(posedge clock);
      if (!failed && result_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
